/* rtl/bcm_pkg.sv */
package bcm_pkg;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 12;
  localparam int CFG_DATA_W     = 12;
  localparam int CFG_INDEX_W    = 2;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int OQ_DEPTH       = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE_DILATE  = 2'd2;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic pixel_in;
    logic fill;
  } mask_word_t;

  typedef struct packed {
    logic pixel_out;
    logic frame_last;
  } result_word_t;

  // per-item control carried from the scan stage to the kernel stage
  typedef struct packed {
    logic p;
    logic emit;
    logic last;
    logic up_ok;
    logic down_ok;
    logic left_ok;
    logic right_ok;
    logic fwd_a;
    logic fwd_b;
  } item_ctl_t;

endpackage

/* rtl/bcm_ram.sv */
module bcm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bcm_scan.sv */
module bcm_scan #(
  parameter int MAX_WIDTH = bcm_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int RW = bcm_pkg::FRAME_HEIGHT_W + 1,
  localparam int EW = (WW > bcm_pkg::FRAME_WIDTH_W) ? WW : bcm_pkg::FRAME_WIDTH_W
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  bcm_pkg::mask_word_t                 word,
  input  logic [bcm_pkg::FRAME_WIDTH_W-1:0]   frame_width,
  input  logic [bcm_pkg::FRAME_HEIGHT_W-1:0]  frame_height,
  input  logic                                restart,
  output logic [CW-1:0]                       rd_addr_a,
  output logic [CW-1:0]                       rd_addr_b,
  output logic                                item_valid,
  output bcm_pkg::item_ctl_t                  item,
  output logic [CW-1:0]                       item_k
);

  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

  logic [CW-1:0] col;
  logic [RW-1:0] row;

  logic [EW-1:0]                       fw_ext;
  logic [EW-1:0]                       w_clamp;
  logic [WW-1:0]                       w;
  logic [CW-1:0]                       wm1;
  logic [bcm_pkg::FRAME_HEIGHT_W-1:0]  h_eff;
  logic [RW-1:0]                       h_row;
  logic [RW-1:0]                       h_plus1;
  logic [CW-1:0]                       cw;
  logic                                col0;
  logic [CW-1:0]                       k;
  logic [CW:0]                         col_inc;
  bcm_pkg::item_ctl_t                  ctl;
  logic [CW-1:0]                       col_next;
  logic [RW-1:0]                       row_next;

  always_comb begin
    fw_ext = EW'(frame_width);
    if (fw_ext < EW'(2)) begin
      w_clamp = EW'(2);
    end else if (fw_ext > MAXW) begin
      w_clamp = MAXW;
    end else begin
      w_clamp = fw_ext;
    end
    w   = WW'(w_clamp);
    wm1 = CW'(w - WW'(1));

    h_eff   = (frame_height < bcm_pkg::FRAME_HEIGHT_W'(2)) ?
              bcm_pkg::FRAME_HEIGHT_W'(2) : frame_height;
    h_row   = RW'(h_eff);
    h_plus1 = h_row + RW'(1);

    cw   = (WW'(col) >= w) ? wm1 : col;
    col0 = (cw == '0);
    k    = col0 ? wm1 : cw - CW'(1);

    ctl.p        = word.pixel_in & ~word.fill & (row < h_row);
    ctl.emit     = col0 ? (row >= RW'(2)) : ((row >= RW'(1)) && (row <= h_row));
    ctl.last     = col0 && (row == h_plus1);
    ctl.up_ok    = col0 ? (row >= RW'(3)) : (row >= RW'(2));
    ctl.down_ok  = col0 ? (row <= h_row) : (row < h_row);
    ctl.left_ok  = col0 | (cw >= CW'(2));
    ctl.right_ok = ~col0;
    // kernel writes this cycle land after our read; bypass them
    ctl.fwd_a    = item_valid && (item_k == k);
    ctl.fwd_b    = item_valid && (item_k == cw);

    col_inc = {1'b0, cw} + (CW+1)'(1);
    if (ctl.last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= (CW+1)'(w)) begin
      col_next = '0;
      row_next = (row == h_plus1) ? row : row + RW'(1);
    end else begin
      col_next = CW'(col_inc);
      row_next = row;
    end
  end

  assign rd_addr_a = k;
  assign rd_addr_b = cw;

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
      if (restart) begin
        col <= '0;
        row <= '0;
      end else if (accept) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item   <= ctl;
      item_k <= k;
    end
  end

endmodule

/* rtl/bcm_kernel.sv */
module bcm_kernel #(
  parameter int MAX_WIDTH = bcm_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  mode_dilate,
  input  logic                  restart,
  input  logic                  item_valid,
  input  bcm_pkg::item_ctl_t    item,
  input  logic [CW-1:0]         item_k,
  input  logic [1:0]            a_rdata,
  input  logic                  b_rdata,
  output logic                  wr_en,
  output logic [CW-1:0]         wr_addr,
  output logic [1:0]            a_wdata,
  output logic                  b_wdata,
  output logic                  push,
  output bcm_pkg::result_word_t push_word
);

  // window[0]: previous incoming pixel, window[1]: left of the filtered pixel
  logic [1:0] window;
  logic [1:0] last_word;

  logic [1:0] a_word;
  logic       centre;
  logic       above;
  logic       rightv;
  logic       pending;
  logic       oldleft;
  logic       and_v;
  logic       or_v;

  always_comb begin
    a_word  = item.fwd_a ? last_word : a_rdata;
    centre  = a_word[0];
    above   = a_word[1];
    rightv  = item.fwd_b ? last_word[0] : b_rdata;
    pending = window[0];
    oldleft = window[1];

    and_v = centre & (~item.up_ok | above) & (~item.down_ok | pending) &
            (~item.left_ok | oldleft) & (~item.right_ok | rightv);
    or_v  = centre | (item.up_ok & above) | (item.down_ok & pending) |
            (item.left_ok & oldleft) | (item.right_ok & rightv);

    push_word.pixel_out  = mode_dilate ? or_v : and_v;
    push_word.frame_last = item.last;
  end

  assign push    = item_valid & item.emit;
  assign wr_en   = item_valid;
  assign wr_addr = item_k;
  assign a_wdata = {centre, pending};
  assign b_wdata = pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (restart) begin
      window <= '0;
    end else if (item_valid) begin
      window <= item.last ? 2'b00 : {centre, item.p};
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      last_word <= {centre, pending};
    end
  end

endmodule

/* rtl/bcm_outq.sv */
module bcm_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bcm_pkg::result_word_t push_word,
  input  logic                  reserve,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bcm_pkg::result_word_t out_word
);

  localparam int DEPTH = bcm_pkg::OQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  bcm_pkg::result_word_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            pop;

  assign out_valid = (count != '0);
  assign out_word  = entries[rd_ptr];
  assign pop       = out_valid & ~out_stall;
  // room for every word in flight plus one more
  assign full      = ((CNTW+1)'(count) + (CNTW+1)'(reserve)) >= (CNTW+1)'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

endmodule

/* rtl/binary_cross_morphology_filter.sv */
// Results lag input by width+1 words in stream terms; the scan stage registers the
// accepted word, the kernel filters it and pushes the result into the output queue.
// Throughput: one word per clock while mask_stall is low, set by the read-modify-write
// of the line buffer RAMs (one write port) and the four-entry output queue.
// Reset (rst, synchronous): position, window and queue cleared, registers to
// 640 x 480 erosion; line buffer RAM contents are left as they are.
module binary_cross_morphology_filter #(
  parameter int MAX_WIDTH = bcm_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               mask_valid,
  output logic                               mask_stall,
  input  bcm_pkg::mask_word_t                mask,
  output logic                               result_valid,
  input  logic                               result_stall,
  output bcm_pkg::result_word_t              result,
  input  logic                               cfg_we,
  input  logic [bcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [bcm_pkg::FRAME_WIDTH_W-1:0]  frame_width;
  logic [bcm_pkg::FRAME_HEIGHT_W-1:0] frame_height;
  logic                               mode_dilate;
  logic [bcm_pkg::FRAME_WIDTH_W-1:0]  frame_width_next;
  logic [bcm_pkg::FRAME_HEIGHT_W-1:0] frame_height_next;
  logic                               mode_dilate_next;
  logic                               restart;

  logic                  accept;
  logic [CW-1:0]         rd_addr_a;
  logic [CW-1:0]         rd_addr_b;
  logic                  item_valid;
  bcm_pkg::item_ctl_t    item;
  logic [CW-1:0]         item_k;
  logic [1:0]            a_rdata;
  logic                  b_rdata;
  logic                  wr_en;
  logic [CW-1:0]         wr_addr;
  logic [1:0]            a_wdata;
  logic                  b_wdata;
  logic                  push;
  bcm_pkg::result_word_t push_word;
  logic                  full;

  always_comb begin
    frame_width_next  = frame_width;
    frame_height_next = frame_height;
    mode_dilate_next  = mode_dilate;
    restart           = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        bcm_pkg::REG_FRAME_WIDTH: begin
          frame_width_next = cfg_data[bcm_pkg::FRAME_WIDTH_W-1:0];
          restart          = 1'b1;
        end
        bcm_pkg::REG_FRAME_HEIGHT: begin
          frame_height_next = cfg_data[bcm_pkg::FRAME_HEIGHT_W-1:0];
          restart           = 1'b1;
        end
        bcm_pkg::REG_MODE_DILATE: begin
          mode_dilate_next = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bcm_pkg::FRAME_WIDTH_RST;
      frame_height <= bcm_pkg::FRAME_HEIGHT_RST;
      mode_dilate  <= 1'b0;
    end else begin
      frame_width  <= frame_width_next;
      frame_height <= frame_height_next;
      mode_dilate  <= mode_dilate_next;
    end
  end

  assign mask_stall = full;
  assign accept     = mask_valid & ~mask_stall;

  bcm_scan #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .word         (mask),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .restart      (restart),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .item_valid   (item_valid),
    .item         (item),
    .item_k       (item_k)
  );

  // {row above, row center} at the filtered column
  bcm_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (a_wdata),
    .raddr (rd_addr_a),
    .rdata (a_rdata)
  );

  // copy of row center for the right neighbor
  bcm_ram #(
    .WIDTH(1),
    .DEPTH(MAX_WIDTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (b_wdata),
    .raddr (rd_addr_b),
    .rdata (b_rdata)
  );

  bcm_kernel #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_kernel (
    .clk         (clk),
    .rst         (rst),
    .mode_dilate (mode_dilate),
    .restart     (restart),
    .item_valid  (item_valid),
    .item        (item),
    .item_k      (item_k),
    .a_rdata     (a_rdata),
    .b_rdata     (b_rdata),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .a_wdata     (a_wdata),
    .b_wdata     (b_wdata),
    .push        (push),
    .push_word   (push_word)
  );

  bcm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .reserve   (item_valid),
    .full      (full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_word  (result)
  );

endmodule

/* tb/binary_cross_morphology_filter_test.sv */
`timescale 1ns / 100ps

module binary_cross_morphology_filter_test;
  import bcm_pkg::*;

  localparam int LINE_MAX = MAX_WIDTH_DEF;
  localparam int RANDOM_WORDS = 1010;
  localparam int QUIET_LIMIT = 4000;
  localparam int REPORT_MAX = 100;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  class cross_filter_model;
    bit above_line [LINE_MAX];
    bit center_line [LINE_MAX];
    int unsigned column;
    int unsigned row;
    bit [1:0] left_below;
    bit [FRAME_WIDTH_W-1:0] width_reg;
    bit [FRAME_HEIGHT_W-1:0] height_reg;
    bit dilate;
    result_word_t filtered_due[$];
    int failures;

    function void clear();
      foreach (above_line[i]) begin
        above_line[i] = 1'b0;
        center_line[i] = 1'b0;
      end
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      dilate = 1'b0;
      filtered_due.delete();
      failures = 0;
      restart();
    endfunction

    function void restart();
      column = 0;
      row = 0;
      left_below = 2'b00;
    endfunction

    function int unsigned line_width();
      int unsigned wv;
      wv = 32'(width_reg);
      if (wv < 2) return 2;
      if (wv > LINE_MAX) return LINE_MAX;
      return wv;
    endfunction

    function int unsigned frame_rows();
      int unsigned hv;
      hv = 32'(height_reg);
      return (hv < 2) ? 2 : hv;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = data[FRAME_WIDTH_W-1:0];
          restart();
        end
        REG_FRAME_HEIGHT: begin
          height_reg = data[FRAME_HEIGHT_W-1:0];
          restart();
        end
        REG_MODE_DILATE: begin
          dilate = data[0];
        end
        default: ;
      endcase
    endfunction

    function bit merge(bit acc, bit v);
      return dilate ? (acc | v) : (acc & v);
    endfunction

    // one word in, at most one filtered pixel out
    function void take_pixel(mask_word_t word);
      int unsigned w, h, c, r, k, back, orow;
      bit pix, below, left, centre, acc, last;
      result_word_t res;
      w = line_width();
      h = frame_rows();
      c = column;
      r = row;
      pix = word.pixel_in && !word.fill && (r < h);
      if (c >= w) c = w - 1;
      if (c == 0) begin
        k = w - 1;
        back = 2;
      end else begin
        k = c - 1;
        back = 1;
      end
      below = left_below[0];
      left = left_below[1];
      centre = center_line[k];
      if (r >= back && r - back < h) begin
        orow = r - back;
        acc = centre;
        if (orow >= 1) acc = merge(acc, above_line[k]);
        if (orow + 1 < h) acc = merge(acc, below);
        if (k >= 1) acc = merge(acc, left);
        if (k + 1 < w) acc = merge(acc, center_line[k + 1]);
        last = (orow + 1 == h) && (k + 1 == w);
        res.pixel_out = acc;
        res.frame_last = last;
        filtered_due.push_back(res);
        if (last) begin
          above_line[k] = centre;
          center_line[k] = below;
          restart();
          return;
        end
      end
      above_line[k] = centre;
      center_line[k] = below;
      left_below = {centre, pix};
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r > h + 1) r = h + 1;
      end
      column = c;
      row = r;
    endfunction

    function void check_filtered(result_word_t got);
      result_word_t want;
      if (filtered_due.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $error("unexpected result word: pixel_out %0b frame_last %0b",
                 got.pixel_out, got.frame_last);
        return;
      end
      want = filtered_due.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        failures++;
        if (failures <= REPORT_MAX)
          $error("pixel_out: expected %0b, got %0b", want.pixel_out, got.pixel_out);
      end
      if (got.frame_last !== want.frame_last) begin
        failures++;
        if (failures <= REPORT_MAX)
          $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
      end
    endfunction

    function int pending();
      return filtered_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic mask_valid;
  logic mask_stall;
  mask_word_t mask;
  logic result_valid;
  logic result_stall;
  result_word_t result;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cross_filter_model model;
  int src_idle_pct;
  int sink_idle_pct;
  int random_sent;
  bit resync;

  binary_cross_morphology_filter u_dut (
    .clk(clk),
    .rst(rst),
    .mask_valid(mask_valid),
    .mask_stall(mask_stall),
    .mask(mask),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) model.check_filtered(result);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (mask_valid && !mask_stall) || (result_valid && !result_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("binary_cross_morphology_filter test failed");
    $finish;
  end

  task automatic push_word(input bit pix, input bit fl);
    mask_word_t word;
    word.pixel_in = pix;
    word.fill = fl;
    if ($urandom_range(99) < src_idle_pct) begin
      mask_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    mask_valid <= 1'b1;
    mask <= word;
    do @(posedge clk); while (mask_stall);
    model.take_pixel(word);
  endtask

  // words taken LSB first from the two bit vectors
  task automatic push_run(input int n, input logic [31:0] pix, input logic [31:0] fl);
    for (int i = 0; i < n; i++) push_word(pix[i], fl[i]);
  endtask

  // sender holds off until every filtered pixel is out and the pipe is empty
  task automatic settle();
    mask_valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    model.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd,
                           input logic [CFG_DATA_W-1:0] md);
    settle();
    write_reg(REG_FRAME_WIDTH, wd);
    write_reg(REG_FRAME_HEIGHT, hd);
    write_reg(REG_MODE_DILATE, md);
  endtask

  task automatic random_frame();
    logic [CFG_DATA_W-1:0] wd;
    logic [CFG_DATA_W-1:0] hd;
    int unsigned w, h, area, span, cut, density, mode_at;
    bit broken;
    if (resync || $urandom_range(3) != 0) begin
      wd = ($urandom_range(15) == 0) ? CFG_DATA_W'($urandom_range(40, 9)) :
                                       CFG_DATA_W'($urandom_range(8, 0));
      wd[CFG_DATA_W-1] = 1'($urandom_range(1));
      hd = ($urandom_range(15) == 0) ? CFG_DATA_W'($urandom_range(20, 8)) :
                                       CFG_DATA_W'($urandom_range(7, 0));
      configure(wd, hd, CFG_DATA_W'($urandom_range(4095)));
      if ($urandom_range(7) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(4095)));
    end
    w = model.line_width();
    h = model.frame_rows();
    area = w * h;
    span = area + w + 1;
    case ($urandom_range(2))
      0: density = 8;
      1: density = 50;
      default: density = 92;
    endcase
    broken = ($urandom_range(9) == 0);
    cut = broken ? $urandom_range(span + w, 1) : span;
    mode_at = ($urandom_range(9) == 0) ? $urandom_range(span - 1, 1) : 0;
    for (int unsigned i = 0; i < cut; i++) begin
      if (mode_at != 0 && i == mode_at) begin
        settle();
        write_reg(REG_MODE_DILATE, CFG_DATA_W'($urandom_range(4095)));
      end
      if (i < area)
        push_word($urandom_range(99) < density, $urandom_range(99) < 3);
      else
        push_word(1'($urandom_range(1)), $urandom_range(9) != 0);
    end
    random_sent += cut;
    resync = broken;
    if ($urandom_range(4) == 0) settle();
  endtask

  initial begin
    model = new;
    model.clear();
    src_idle_pct = 32;
    sink_idle_pct = 53;
    random_sent = 0;
    resync = 1'b0;
    rst <= 1'b1;
    mask_valid <= 1'b0;
    mask <= '0;
    result_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: the start of a 640-wide frame, cut off by the next size write
    repeat (8) push_word(1'($urandom_range(1)), 1'b0);

    // clamped 2x2 erosion, all ones
    configure(12'h800, 12'd1, 12'd0);
    push_run(7, 32'b0001111, 32'b1110000);

    // clamped 2x2 dilation; fill inside the frame, plain pixel in the tail
    configure(12'd1, 12'd0, 12'hFFF);
    push_run(7, 32'b0110011, 32'b1100010);

    // spare index ignored; 3x2 with the mode flipped mid-frame
    settle();
    write_reg(REG_SPARE, 12'h5A5);
    configure(12'd3, 12'd2, 12'd0);
    push_run(5, 32'b10111, 32'b00000);
    settle();
    write_reg(REG_MODE_DILATE, 12'd1);
    push_run(5, 32'b00001, 32'b11110);

    // tallest frame, started and then aborted
    configure(12'd2, 12'hFFF, 12'd1);
    repeat (9) push_word(1'($urandom_range(1)), 1'b0);
    resync = 1'b1;

    while (random_sent < RANDOM_WORDS) begin
      if (random_sent >= 2 * RANDOM_WORDS / 3) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else if (random_sent >= RANDOM_WORDS / 3) begin
        src_idle_pct = 53;
        sink_idle_pct = 32;
      end
      random_frame();
    end

    settle();
    if (model.failures == 0)
      $display("binary_cross_morphology_filter test passed");
    else
      $display("binary_cross_morphology_filter test failed");
    $finish;
  end

endmodule
